### hw/rtl/osm_pkg.sv
// ----------------------------------------------------------------------------
// osm_pkg: shared types and codes for the order statistic multiset
// Operation and status codes, the per-cell command and the tree step.
// ----------------------------------------------------------------------------
package osm_pkg;

  // Default number of values the store can hold
  localparam int CAPACITY_DEF = 1024;

  // Levels of the reduction tree between two register ranks
  localparam int TREE_STEP = 3;

  // Operation codes carried by in_kind
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  // Status codes reported on out_status
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_NOTFOUND = 2'd2;
  localparam logic [1:0] STAT_RANGE    = 2'd3;

  // Update a cell applies at the end of the current cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  // Command broadcast from the sequencer to every cell
  typedef struct packed {
    cell_op_t           op;
    logic signed [31:0] val;
    logic               query;
    logic               rank_ok;
  } cell_ctrl_t;

endpackage

### hw/rtl/osm_cell.sv
// ----------------------------------------------------------------------------
// osm_cell: one slot of the sorted value chain
// Holds one value, compares it with the broadcast operand and shifts toward
// its right neighbor on insert or takes the right neighbor's value on remove.
// ----------------------------------------------------------------------------
module osm_cell #(
  parameter int IW  = 10,
  parameter int CW  = 11,
  parameter int IDX = 0
) (
  input  logic                    clk,
  input  osm_pkg::cell_ctrl_t     ctrl,
  input  logic [CW-1:0]           count,
  input  logic [IW-1:0]           qidx,
  input  logic signed [31:0]      left_v,
  input  logic                    left_gt,
  input  logic signed [31:0]      right_v,
  output logic signed [31:0]      v,
  output logic                    gt,
  output logic [32:0]             leaf
);

  logic signed [31:0] v_r;
  logic signed [31:0] v_nxt;
  logic               in_use;
  logic               at_tail;
  logic               ge;
  logic               eq;
  logic               sel;

  // Slot position against the fill level
  assign in_use  = CW'(IDX) < count;
  assign at_tail = CW'(IDX) == count;

  // Signed compares against the operand
  assign gt = in_use && (v_r > ctrl.val);
  assign ge = in_use && (v_r >= ctrl.val);
  assign eq = in_use && (v_r == ctrl.val);

  // Query select and tree leaf: hit flag over data
  assign sel  = ctrl.rank_ok && (qidx == IW'(IDX));
  assign leaf = ctrl.query ? {sel, (sel ? v_r : 32'sd0)} : {eq, 32'd0};

  assign v = v_r;

  // Next slot value
  always_comb begin
    v_nxt = v_r;
    case (ctrl.op)
      osm_pkg::CELL_INSERT: begin
        if (in_use || at_tail) begin
          if (left_gt) begin
            v_nxt = left_v;
          end else if (gt || at_tail) begin
            v_nxt = ctrl.val;
          end
        end
      end
      osm_pkg::CELL_REMOVE: begin
        if (ge) begin
          v_nxt = right_v;
        end
      end
      default: v_nxt = v_r;
    endcase
  end

  always_ff @(posedge clk) begin
    v_r <= v_nxt;
  end

endmodule

### hw/rtl/osm_or_tree.sv
// ----------------------------------------------------------------------------
// osm_or_tree: pipelined OR reduction over the cell leaves
// Binary tree with a register rank every TREE_STEP levels and at the root.
// ----------------------------------------------------------------------------
module osm_or_tree #(
  parameter int N = 1024,
  parameter int W = 33
) (
  input  logic         clk,
  input  logic [W-1:0] leaf [N],
  output logic [W-1:0] root
);

  localparam int L = $clog2(N);
  localparam int P = 1 << L;

  logic [W-1:0] tap [1:2*P-1];

  // Leaves, padded with zeros up to a power of two
  for (genvar j = 0; j < P; j++) begin : g_leaf
    if (j < N) begin : g_real
      assign tap[P+j] = leaf[j];
    end else begin : g_pad
      assign tap[P+j] = '0;
    end
  end

  // Inner nodes, heap order: node k merges 2k and 2k+1
  for (genvar k = 1; k < P; k++) begin : g_node
    localparam int HGT = L - ($clog2(k + 1) - 1);
    if ((HGT % osm_pkg::TREE_STEP) == 0 || k == 1) begin : g_reg
      logic [W-1:0] q;
      always_ff @(posedge clk) begin
        q <= tap[2*k] | tap[2*k+1];
      end
      assign tap[k] = q;
    end else begin : g_comb
      assign tap[k] = tap[2*k] | tap[2*k+1];
    end
  end

  assign root = tap[1];

endmodule

### hw/rtl/order_statistic_multiset.sv
// ----------------------------------------------------------------------------
// order_statistic_multiset: sorted multiset with insert, remove and k-th query
// A chain of CAPACITY cells keeps the values in ascending order.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low. Insert and the
// unused fourth code go from the accept straight to the update state, in
// which every cell shifts in parallel. Remove and query first wait in ST_LOOK
// for the pipelined OR tree that gathers the match flag or the selected value
// from the cells. The busy output stays high until the result is out, so
// operations never overlap. Each result appears on the out_ ports for exactly
// one cycle, marked by out_valid, registered at the same edge as the update;
// the receiver has no way to stall it and must take it then. No clearing pass
// is needed after reset: slots at or above the fill count are never read.
module order_statistic_multiset #(
  parameter int CAPACITY = osm_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_kind,
  input  logic signed [31:0] in_value,
  input  logic [10:0]        in_rank,
  output logic               out_valid,
  output logic signed [31:0] out_answer,
  output logic [1:0]         out_status,
  output logic [10:0]        out_occupancy
);

  localparam int IW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int LAT = (IW + osm_pkg::TREE_STEP - 1) / osm_pkg::TREE_STEP;
  localparam int LCW = (LAT > 1) ? $clog2(LAT) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_APPLY
  } state_t;

  state_t             state_r;
  logic [CW-1:0]      count_r;
  logic [LCW-1:0]     cnt_r;
  logic [1:0]         kind_r;
  logic signed [31:0] val_r;
  logic [IW-1:0]      qidx_r;
  logic               rank_ok_r;
  logic               out_valid_r;
  logic signed [31:0] out_answer_r;
  logic [1:0]         out_status_r;
  logic [10:0]        out_occupancy_r;

  logic                accept;
  logic                rank_ok_nxt;
  osm_pkg::cell_op_t   cell_op;
  osm_pkg::cell_ctrl_t ctrl;
  logic [CW-1:0]       count_nxt;
  logic [1:0]          status_nxt;
  logic signed [31:0]  answer_nxt;
  logic [32:0]         root;

  logic signed [31:0]  v_w    [CAPACITY];
  logic                gt_w   [CAPACITY];
  logic [32:0]         leaf_w [CAPACITY];

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // Rank check against the current fill level
  assign rank_ok_nxt = (in_rank != 11'd0) && (32'(in_rank) <= 32'(count_r));

  // Broadcast command; cells only change in the update cycle
  assign ctrl.op      = (state_r == ST_APPLY) ? cell_op : osm_pkg::CELL_HOLD;
  assign ctrl.val     = val_r;
  assign ctrl.query   = (kind_r == osm_pkg::KIND_QUERY);
  assign ctrl.rank_ok = rank_ok_r;

  // Cell chain: values and greater-than flags move right, values move left
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] lv;
    logic               lg;
    logic signed [31:0] rv;
    if (i == 0) begin : g_first
      assign lv = 32'sd0;
      assign lg = 1'b0;
    end else begin : g_mid
      assign lv = v_w[i-1];
      assign lg = gt_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign rv = v_w[i];
    end else begin : g_inner
      assign rv = v_w[i+1];
    end
    osm_cell #(
      .IW  (IW),
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .count   (count_r),
      .qidx    (qidx_r),
      .left_v  (lv),
      .left_gt (lg),
      .right_v (rv),
      .v       (v_w[i]),
      .gt      (gt_w[i]),
      .leaf    (leaf_w[i])
    );
  end

  // Match flag and selected value gathered from all cells
  osm_or_tree #(
    .N (CAPACITY),
    .W (33)
  ) u_tree (
    .clk  (clk),
    .leaf (leaf_w),
    .root (root)
  );

  // Outcome of the latched operation
  always_comb begin
    cell_op    = osm_pkg::CELL_HOLD;
    count_nxt  = count_r;
    status_nxt = osm_pkg::STAT_OK;
    answer_nxt = 32'sd0;
    unique case (kind_r)
      osm_pkg::KIND_INSERT: begin
        if (count_r == CW'(CAPACITY)) begin
          status_nxt = osm_pkg::STAT_FULL;
        end else begin
          cell_op   = osm_pkg::CELL_INSERT;
          count_nxt = count_r + CW'(1);
        end
      end
      osm_pkg::KIND_REMOVE: begin
        if (root[32]) begin
          cell_op   = osm_pkg::CELL_REMOVE;
          count_nxt = count_r - CW'(1);
        end else begin
          status_nxt = osm_pkg::STAT_NOTFOUND;
        end
      end
      osm_pkg::KIND_QUERY: begin
        if (rank_ok_r) begin
          answer_nxt = root[31:0];
        end else begin
          status_nxt = osm_pkg::STAT_RANGE;
        end
      end
      default: cell_op = osm_pkg::CELL_HOLD;
    endcase
  end

  // Sequencer, operand latch and result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            kind_r    <= in_kind;
            val_r     <= in_value;
            qidx_r    <= IW'(in_rank - 11'd1);
            rank_ok_r <= rank_ok_nxt;
            cnt_r     <= LCW'(LAT - 1);
            if (in_kind == osm_pkg::KIND_REMOVE || in_kind == osm_pkg::KIND_QUERY) begin
              state_r <= ST_LOOK;
            end else begin
              state_r <= ST_APPLY;
            end
          end
        end
        ST_LOOK: begin
          if (cnt_r == '0) begin
            state_r <= ST_APPLY;
          end else begin
            cnt_r <= cnt_r - LCW'(1);
          end
        end
        ST_APPLY: begin
          count_r         <= count_nxt;
          out_valid_r     <= 1'b1;
          out_answer_r    <= answer_nxt;
          out_status_r    <= status_nxt;
          out_occupancy_r <= 11'(count_nxt);
          state_r         <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_answer    = out_answer_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occupancy_r;

endmodule

### sim/order_statistic_multiset_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_statistic_multiset_tb: self-checking bench for the sorted multiset
// Drives insert, remove and rank query beats through the start/busy port and
// checks every strobed result against a queue-based model of the store or a
// typed table result. Runs a directed table first, then fills the store past
// capacity, drains it back down, and finishes with a long random mix.
// ----------------------------------------------------------------------------
module order_statistic_multiset_tb;

  localparam int CAPACITY     = osm_pkg::CAPACITY_DEF;
  localparam int RANDOM_BEATS = 700;
  localparam int DIR_ROWS     = 24;
  localparam int SETTLE_CYC   = 32;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int REPORT_MAX   = 10;

  // Spare opcode, not named in the package; the block treats it as a no-op
  localparam logic [1:0] KIND_SPARE = 2'd3;

  typedef struct packed {
    logic signed [31:0] answer;
    logic [1:0]         status;
    logic [10:0]        occupancy;
  } outcome_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] value;
    logic [10:0]        rank;
    bit                 typed;
    outcome_t           res;
  } dir_row_t;

  logic               clk;
  logic               rst_n         = 1'b0;
  logic               start         = 1'b0;
  logic               busy;
  logic [1:0]         in_kind       = osm_pkg::KIND_INSERT;
  logic signed [31:0] in_value      = '0;
  logic [10:0]        in_rank       = '0;
  logic               out_valid;
  logic signed [31:0] out_answer;
  logic [1:0]         out_status;
  logic [10:0]        out_occupancy;

  // Model of the store contents, ascending, and results still to come
  logic signed [31:0] held_q[$];
  outcome_t           pending_q[$];
  outcome_t           head_res;
  int                 fail_count = 0;
  int                 cycle_count = 0;

  // Directed table: typed results only where they follow at a glance
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{osm_pkg::KIND_QUERY, 32'sd0, 11'd1, 1'b1, '{32'sd0, osm_pkg::STAT_RANGE, 11'd0}},
    '{osm_pkg::KIND_REMOVE, 32'sd5, 11'd0, 1'b1, '{32'sd0, osm_pkg::STAT_NOTFOUND, 11'd0}},
    '{KIND_SPARE, 32'sd0, 11'd0, 1'b1, '{32'sd0, osm_pkg::STAT_OK, 11'd0}},
    '{osm_pkg::KIND_INSERT, 32'sh7FFFFFFF, 11'd0, 1'b1, '{32'sd0, osm_pkg::STAT_OK, 11'd1}},
    '{osm_pkg::KIND_INSERT, 32'sh80000000, 11'd0, 1'b1, '{32'sd0, osm_pkg::STAT_OK, 11'd2}},
    '{osm_pkg::KIND_INSERT, 32'sd0, 11'd0, 1'b1, '{32'sd0, osm_pkg::STAT_OK, 11'd3}},
    '{osm_pkg::KIND_INSERT, 32'sd0, 11'h7FF, 1'b1, '{32'sd0, osm_pkg::STAT_OK, 11'd4}},
    '{osm_pkg::KIND_INSERT, -32'sd1, 11'd0, 1'b0, '0},
    '{osm_pkg::KIND_QUERY, 32'sd0, 11'd1, 1'b1, '{32'sh80000000, osm_pkg::STAT_OK, 11'd5}},
    '{osm_pkg::KIND_QUERY, 32'sd0, 11'd5, 1'b1, '{32'sh7FFFFFFF, osm_pkg::STAT_OK, 11'd5}},
    '{osm_pkg::KIND_QUERY, 32'sd0, 11'd0, 1'b1, '{32'sd0, osm_pkg::STAT_RANGE, 11'd5}},
    '{osm_pkg::KIND_QUERY, 32'sd0, 11'd6, 1'b1, '{32'sd0, osm_pkg::STAT_RANGE, 11'd5}},
    '{osm_pkg::KIND_QUERY, 32'shFFFFFFFF, 11'h7FF, 1'b1,
      '{32'sd0, osm_pkg::STAT_RANGE, 11'd5}},
    '{osm_pkg::KIND_QUERY, 32'sd0, 11'd3, 1'b0, '0},
    '{osm_pkg::KIND_REMOVE, 32'sd0, 11'd0, 1'b1, '{32'sd0, osm_pkg::STAT_OK, 11'd4}},
    '{osm_pkg::KIND_QUERY, 32'sd0, 11'd3, 1'b0, '0},
    '{osm_pkg::KIND_REMOVE, 32'sd12345, 11'd0, 1'b1,
      '{32'sd0, osm_pkg::STAT_NOTFOUND, 11'd4}},
    '{osm_pkg::KIND_REMOVE, 32'sh7FFFFFFF, 11'd0, 1'b1, '{32'sd0, osm_pkg::STAT_OK, 11'd3}},
    '{KIND_SPARE, 32'shFFFFFFFF, 11'h7FF, 1'b1, '{32'sd0, osm_pkg::STAT_OK, 11'd3}},
    '{osm_pkg::KIND_INSERT, 32'sh55555555, 11'd0, 1'b0, '0},
    '{osm_pkg::KIND_INSERT, 32'shAAAAAAAA, 11'd0, 1'b0, '0},
    '{osm_pkg::KIND_QUERY, 32'sd0, 11'd2, 1'b0, '0},
    '{osm_pkg::KIND_REMOVE, 32'sh80000000, 11'd0, 1'b0, '0},
    '{osm_pkg::KIND_QUERY, 32'sd0, 11'd4, 1'b0, '0}
  };

  order_statistic_multiset #(
    .CAPACITY(CAPACITY)
  ) u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_kind      (in_kind),
    .in_value     (in_value),
    .in_rank      (in_rank),
    .out_valid    (out_valid),
    .out_answer   (out_answer),
    .out_status   (out_status),
    .out_occupancy(out_occupancy)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Apply one operation to the model store and return its result
  function automatic outcome_t apply_store_op(logic [1:0] kind, logic signed [31:0] value,
                                              logic [10:0] rank);
    outcome_t r;
    int       pos;
    r.answer = '0;
    r.status = osm_pkg::STAT_OK;
    case (kind)
      osm_pkg::KIND_INSERT: begin
        if (held_q.size() >= CAPACITY) begin
          r.status = osm_pkg::STAT_FULL;
        end else begin
          // duplicates land after the copies already held
          pos = held_q.size();
          while (pos > 0 && held_q[pos-1] > value) pos--;
          held_q.insert(pos, value);
        end
      end
      osm_pkg::KIND_REMOVE: begin
        pos = -1;
        foreach (held_q[i]) if (pos < 0 && held_q[i] == value) pos = i;
        if (pos < 0) r.status = osm_pkg::STAT_NOTFOUND;
        else held_q.delete(pos);
      end
      osm_pkg::KIND_QUERY: begin
        if (rank == 0 || int'(rank) > held_q.size()) r.status = osm_pkg::STAT_RANGE;
        else r.answer = held_q[rank-1];
      end
      default: ;
    endcase
    r.occupancy = 11'(held_q.size());
    return r;
  endfunction

  // Value mix: small pool for duplicates and hits, extremes, full range
  function automatic logic signed [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return $signed(32'($urandom_range(0, 15)) - 32'd8);
    if (sel < 55) begin
      case ($urandom_range(0, 3))
        0: return 32'sh80000000;
        1: return 32'sh7FFFFFFF;
        2: return -32'sd1;
        default: return 32'sd0;
      endcase
    end
    return $signed($urandom());
  endfunction

  // Rank mix: mostly in range, with zero, one past the end and raw 11-bit
  function automatic logic [10:0] pick_rank();
    int sel;
    int sz;
    sel = $urandom_range(0, 99);
    sz  = held_q.size();
    if (sel < 70) return 11'($urandom_range(1, (sz > 0) ? sz : 1));
    if (sel < 80) return 11'd0;
    if (sel < 90) return 11'(sz + 1);
    return 11'($urandom_range(0, 2047));
  endfunction

  // Present one beat and hold it until the block takes it
  task automatic send_op(input logic [1:0] kind, input logic signed [31:0] value,
                         input logic [10:0] rank, input bit typed, input outcome_t typed_res);
    outcome_t predicted;
    start    <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    in_rank  <= rank;
    do @(posedge clk); while (busy);
    predicted = apply_store_op(kind, value, rank);
    pending_q.push_back(typed ? typed_res : predicted);
  endtask

  // Random gap between beats
  task automatic maybe_idle(input bit quiet);
    if (!quiet && $urandom_range(0, 99) < 9) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Hold off until every outstanding result has come back
  task automatic wait_all_results();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("ERROR: unexpected result beat answer=%0d status=%0d occ=%0d",
                   out_answer, out_status, out_occupancy);
      end else begin
        head_res = pending_q.pop_front();
        if (out_answer !== head_res.answer || out_status !== head_res.status ||
            out_occupancy !== head_res.occupancy) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display({"ERROR: exp answer=%0d status=%0d occ=%0d, ",
                      "got answer=%0d status=%0d occ=%0d"},
                     head_res.answer, head_res.status, head_res.occupancy,
                     out_answer, out_status, out_occupancy);
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [1:0]         kind;
    logic signed [31:0] value;
    int                 sel;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      send_op(dir_tab[i].kind, dir_tab[i].value, dir_tab[i].rank,
              dir_tab[i].typed, dir_tab[i].res);
      maybe_idle(1'b0);
    end
    wait_all_results();

    // Fill to capacity, then push against the full store
    while (held_q.size() < CAPACITY + 0) begin
      send_op(osm_pkg::KIND_INSERT, pick_value(), 11'($urandom_range(0, 2047)), 1'b0, '0);
      maybe_idle(1'b0);
    end
    for (int i = 0; i < 3; i++) begin
      send_op(osm_pkg::KIND_INSERT, pick_value(), 11'd0, 1'b0, '0);
      maybe_idle(1'b0);
    end
    send_op(osm_pkg::KIND_QUERY, 32'sd0, 11'd1024, 1'b0, '0);
    send_op(osm_pkg::KIND_QUERY, 32'sd0, 11'd1025, 1'b0, '0);
    send_op(osm_pkg::KIND_QUERY, 32'sd0, 11'd1, 1'b0, '0);
    send_op(osm_pkg::KIND_QUERY, 32'sd0, 11'h7FF, 1'b0, '0);
    wait_all_results();

    // Drain back down by removing held copies
    while (held_q.size() > 16) begin
      send_op(osm_pkg::KIND_REMOVE, held_q[$urandom_range(0, held_q.size() - 1)],
              11'($urandom_range(0, 2047)), 1'b0, '0);
      maybe_idle(1'b0);
    end
    wait_all_results();

    // Random mix, with a long stretch of back-to-back beats
    for (int n = 0; n < RANDOM_BEATS; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) kind = osm_pkg::KIND_INSERT;
      else if (sel < 75) kind = osm_pkg::KIND_REMOVE;
      else if (sel < 97) kind = osm_pkg::KIND_QUERY;
      else kind = KIND_SPARE;
      if (kind == osm_pkg::KIND_REMOVE && held_q.size() > 0 && $urandom_range(0, 99) < 60)
        value = held_q[$urandom_range(0, held_q.size() - 1)];
      else
        value = pick_value();
      send_op(kind, value, pick_rank(), 1'b0, '0);
      if ($urandom_range(0, 99) == 0) wait_all_results();
      else maybe_idle(n >= 250 && n < 450);
    end

    // Final drain and settle
    wait_all_results();
    repeat (SETTLE_CYC) @(posedge clk);
    if (fail_count == 0 && pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
